// ===== rtl/core/sparse_triplet_fast_transpose_top_macros.svh =====
// Assertion helpers for the checker module.
`ifndef SPARSE_TRIPLET_FAST_TRANSPOSE_TOP_MACROS_SVH
`define SPARSE_TRIPLET_FAST_TRANSPOSE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define STFT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define STFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// Same-cycle implication that also holds around reset.
`define STFT_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/core/stft_pkg.sv =====
`default_nettype none

package stft_pkg;

  // Field widths
  localparam int ROW_W     = 5;
  localparam int COL_W     = 5;
  localparam int VAL_W     = 32;
  localparam int DIM_W     = 6;
  localparam int CNT_OUT_W = 7;

  // Stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // Config register indexes
  localparam int         CFG_IDX_W    = 1;
  localparam logic [0:0] CFG_NUM_ROWS = 1'b0;
  localparam logic [0:0] CFG_NUM_COLS = 1'b1;
  localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

  // Queue depths
  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 2;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
  } triplet_t;

  // Work handed from the front to the back
  typedef struct packed {
    logic     keep;   // entry to store
    logic     last;   // end of matrix, run the transpose
    logic     drop;   // some entry of this matrix was dropped
    triplet_t ent;
  } cmd_t;

  typedef struct packed {
    logic                   dropped;
    logic [CNT_OUT_W-1:0]   entry_count;
    logic                   last_out;
    logic signed [VAL_W-1:0] value;
    logic [COL_W-1:0]       col;
    logic [ROW_W-1:0]       row;
  } res_t;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);
  localparam int TRI_W = $bits(triplet_t);

endpackage

`default_nettype wire

// ===== rtl/core/stft_fifo.sv =====
`default_nettype none

module stft_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           head,
  output logic                       not_empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             push_ok;
  logic             pop_ok;

  assign not_empty = (level != '0);
  assign full      = (level == LW'(DEPTH));
  assign head      = slots[rd_ptr];
  assign push_ok   = push && !full;
  assign pop_ok    = pop && not_empty;

  // Storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/stft_ram.sv =====
`default_nettype none

module stft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/stft_front.sv =====
`default_nettype none

module stft_front #(
  parameter int MAX_DIM     = 32,
  parameter int MAX_ENTRIES = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // config writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stft_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stft_pkg::DIM_W-1:0]          cfg_data,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [stft_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic                                s_tuser,
  input  logic                                s_tlast,
  // command queue
  input  logic                                q_full,
  output logic                                q_push,
  output stft_pkg::cmd_t                      q_cmd
);

  import stft_pkg::*;

  localparam int KW = $clog2(MAX_ENTRIES+1);

  logic [DIM_W-1:0] num_rows;
  logic [DIM_W-1:0] num_cols;
  logic [KW-1:0]    kept;
  logic             drop_acc;

  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic [VAL_W-1:0] in_value;
  logic             in_range;
  logic             store_full;
  logic             keep;
  logic             drop;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;

  // Unpack and classify the incoming triplet
  always_comb begin
    in_row     = s_tdata[ROW_W-1:0];
    in_col     = s_tdata[ROW_W+COL_W-1:ROW_W];
    in_value   = s_tdata[ROW_W+COL_W+VAL_W-1:ROW_W+COL_W];
    in_range   = ({1'b0, in_row} < num_rows) && ({1'b0, in_col} < num_cols)
                 && (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
    store_full = (kept == KW'(MAX_ENTRIES));
    keep       = s_tuser && in_range && !store_full;
    drop       = s_tuser && !keep;

    q_push       = accept && (keep || s_tlast);
    q_cmd.keep   = keep;
    q_cmd.last   = s_tlast;
    q_cmd.drop   = drop_acc || drop;
    q_cmd.ent    = '{row: in_row, col: in_col, value: in_value};
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= DIM_RESET;
      num_cols <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_ROWS: num_rows <= cfg_data;
        CFG_NUM_COLS: num_cols <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Per-matrix fill count and sticky drop
  always_ff @(posedge clk) begin
    if (rst) begin
      kept     <= '0;
      drop_acc <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        kept     <= '0;
        drop_acc <= 1'b0;
      end else begin
        if (keep) begin
          kept <= kept + 1'b1;
        end
        if (drop) begin
          drop_acc <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/stft_back.sv =====
`default_nettype none

module stft_back #(
  parameter int MAX_DIM     = 32,
  parameter int MAX_ENTRIES = 64
) (
  input  logic                                        clk,
  input  logic                                        rst,
  // command queue
  input  logic                                        q_valid,
  input  stft_pkg::cmd_t                              q_cmd,
  output logic                                        q_pop,
  // result queue
  input  logic [$clog2(stft_pkg::OUTQ_DEPTH+1)-1:0]   o_level,
  input  logic                                        o_pop,
  output logic                                        o_push,
  output stft_pkg::res_t                              o_data
);

  import stft_pkg::*;

  localparam int COL_SPAN = 1 << COL_W;
  localparam int CNT_N    = (MAX_DIM < COL_SPAN) ? MAX_DIM : COL_SPAN;
  localparam int CW       = $clog2(CNT_N);
  localparam int KW       = $clog2(MAX_ENTRIES+1);
  localparam int AW       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int LW       = $clog2(OUTQ_DEPTH+1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREFIX,
    S_SCATTER,
    S_EMIT
  } state_t;

  state_t        state;
  logic [KW-1:0] wr_ptr;
  logic [KW-1:0] n_reg;
  logic          drop_reg;
  logic [CW-1:0] p_idx;
  logic [KW-1:0] acc;
  logic [KW-1:0] k;
  logic          scat_vld;
  logic          emit_vld;
  logic          emit_last;
  logic [KW-1:0] counts   [CNT_N];
  logic [KW-1:0] next_pos [CNT_N];

  logic             take_ok;
  logic             room_emit;
  logic [KW-1:0]    n_new;
  logic             empty_push;
  logic             emit_issue;
  logic             k_is_last;
  logic             ent_we;
  logic [TRI_W-1:0] ent_rraw;
  logic [TRI_W-1:0] trans_rraw;
  triplet_t         ent_rdata;
  triplet_t         trans_rdata;
  triplet_t         trans_wdata;
  logic [CW-1:0]    scat_col;
  logic [KW-1:0]    slot;

  // Kept entries in arrival order
  stft_ram #(
    .WIDTH (TRI_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (wr_ptr[AW-1:0]),
    .wdata (q_cmd.ent),
    .raddr (k[AW-1:0]),
    .rdata (ent_rraw)
  );

  // Entries placed in transposed order
  stft_ram #(
    .WIDTH (TRI_W),
    .DEPTH (MAX_ENTRIES)
  ) u_trans_ram (
    .clk   (clk),
    .we    (scat_vld),
    .waddr (slot[AW-1:0]),
    .wdata (trans_wdata),
    .raddr (k[AW-1:0]),
    .rdata (trans_rraw)
  );

  // Control decisions and scatter datapath
  always_comb begin
    ent_rdata   = triplet_t'(ent_rraw);
    trans_rdata = triplet_t'(trans_rraw);

    // a finishing command needs a free result slot; wait out any read in flight
    take_ok    = !emit_vld && (!q_cmd.last || (o_level < LW'(OUTQ_DEPTH)));
    q_pop      = (state == S_IDLE) && q_valid && take_ok;
    n_new      = wr_ptr + KW'(q_cmd.keep);
    ent_we     = q_pop && q_cmd.keep;
    empty_push = q_pop && q_cmd.last && (n_new == '0);

    // credit: queued results plus the read in flight, less the one leaving
    room_emit  = ((3'(o_level) + 3'(emit_vld)) < (3'(OUTQ_DEPTH) + 3'(o_pop)));
    emit_issue = (state == S_EMIT) && !scat_vld && room_emit;
    k_is_last  = (k == KW'(n_reg - 1'b1));

    scat_col    = ent_rdata.col[CW-1:0];
    slot        = next_pos[scat_col];
    trans_wdata = '{row: ent_rdata.col, col: ent_rdata.row, value: ent_rdata.value};

    o_push = emit_vld || empty_push;
    if (emit_vld) begin
      o_data.row         = trans_rdata.row;
      o_data.col         = trans_rdata.col;
      o_data.value       = trans_rdata.value;
      o_data.last_out    = emit_last;
      o_data.entry_count = CNT_OUT_W'(n_reg);
      o_data.dropped     = drop_reg;
    end else begin
      o_data.row         = '0;
      o_data.col         = '0;
      o_data.value       = '0;
      o_data.last_out    = 1'b1;
      o_data.entry_count = '0;
      o_data.dropped     = q_cmd.drop;
    end
  end

  // Sequencer: store, prefix sum, scatter, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wr_ptr   <= '0;
      k        <= '0;
      scat_vld <= 1'b0;
      emit_vld <= 1'b0;
      for (int i = 0; i < CNT_N; i++) begin
        counts[i] <= '0;
      end
    end else begin
      // one entry read per scatter cycle, written back in the following cycle
      scat_vld <= (state == S_SCATTER);
      emit_vld <= emit_issue;
      if (emit_issue) begin
        emit_last <= k_is_last;
      end
      // scatter write-back of the bumped slot
      if (scat_vld) begin
        next_pos[scat_col] <= slot + 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_cmd.keep) begin
              counts[q_cmd.ent.col[CW-1:0]] <= counts[q_cmd.ent.col[CW-1:0]] + 1'b1;
            end
            if (q_cmd.last) begin
              wr_ptr   <= '0;
              n_reg    <= n_new;
              drop_reg <= q_cmd.drop;
              if (n_new != '0) begin
                state <= S_PREFIX;
                p_idx <= '0;
                acc   <= '0;
              end
            end else if (q_cmd.keep) begin
              wr_ptr <= n_new;
            end
          end
        end

        S_PREFIX: begin
          next_pos[p_idx] <= acc;
          acc             <= acc + counts[p_idx];
          p_idx           <= p_idx + 1'b1;
          if (p_idx == CW'(CNT_N-1)) begin
            for (int i = 0; i < CNT_N; i++) begin
              counts[i] <= '0;
            end
            state <= S_SCATTER;
            k     <= '0;
          end
        end

        S_SCATTER: begin
          if (k_is_last) begin
            state <= S_EMIT;
            k     <= '0;
          end else begin
            k <= k + 1'b1;
          end
        end

        S_EMIT: begin
          if (emit_issue) begin
            k <= k + 1'b1;
            if (k_is_last) begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sparse_triplet_fast_transpose_top.sv =====
// Channel | Dir | Handshake          | Payload
// s       | in  | s_tvalid/s_tready  | tdata: in_row, in_col, in_value; tuser: has_entry;
//         |     |                    | tlast: last_in
// m       | out | m_tvalid/m_tready  | tdata: out_row, out_col, out_value, entry_count,
//         |     |                    | dropped; tlast: last_out
// cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (0 num_rows, 1 num_cols)
//
// Items are taken one a cycle while the 4-deep command queue, which parts the front
// from the transpose engine, has room. After the last item the engine runs the column
// prefix sum over min(MAX_DIM, 32) columns, the scatter (one registered entry-memory
// read per cycle) and emission, one result a cycle while the output queue has room.
// rst is synchronous; it clears control state and sets both dimensions to 32.
// m_tready low holds results in a 2-entry output queue; the front keeps taking
// items until the command queue fills.
`default_nettype none

module sparse_triplet_fast_transpose_top #(
  parameter int MAX_DIM     = 32,
  parameter int MAX_ENTRIES = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stft_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stft_pkg::DIM_W-1:0]          cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [4:0] in_row, [9:5] in_col, [41:10] in_value, [47:42] zero
  input  logic [stft_pkg::IN_TDATA_W-1:0]     s_tdata,
  // [0] has_entry
  input  logic                                s_tuser,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [4:0] out_row, [9:5] out_col, [41:10] out_value, [48:42] entry_count,
  // [49] dropped, [55:50] zero
  output logic [stft_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tlast
);

  import stft_pkg::*;

  localparam int CLW = $clog2(CMDQ_DEPTH+1);
  localparam int OLW = $clog2(OUTQ_DEPTH+1);

  logic             cq_push;
  logic             cq_full;
  logic             cq_valid;
  logic             cq_pop;
  logic [CLW-1:0]   cq_level;
  cmd_t             cq_in;
  logic [CMD_W-1:0] cq_head;
  cmd_t             cq_cmd;

  logic             oq_push;
  logic             oq_full;
  logic             oq_pop;
  logic [OLW-1:0]   oq_level;
  res_t             oq_in;
  logic [RES_W-1:0] oq_head;
  res_t             res;

  // Front: config, classification, drop tracking
  stft_front #(
    .MAX_DIM     (MAX_DIM),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .q_full    (cq_full),
    .q_push    (cq_push),
    .q_cmd     (cq_in)
  );

  // Command queue between front and back
  stft_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst       (rst),
    .push      (cq_push),
    .push_data (cq_in),
    .pop       (cq_pop),
    .head      (cq_head),
    .not_empty (cq_valid),
    .full      (cq_full),
    .level     (cq_level)
  );

  assign cq_cmd = cmd_t'(cq_head);

  // Back: transpose engine
  stft_back #(
    .MAX_DIM     (MAX_DIM),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (cq_valid && (cq_level != '0)),
    .q_cmd   (cq_cmd),
    .q_pop   (cq_pop),
    .o_level (oq_level),
    .o_pop   (oq_pop),
    .o_push  (oq_push),
    .o_data  (oq_in)
  );

  // Result queue feeding the output stream
  stft_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUTQ_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (oq_push),
    .push_data (oq_in),
    .pop       (oq_pop),
    .head      (oq_head),
    .not_empty (m_tvalid),
    .full      (oq_full),
    .level     (oq_level)
  );

  assign oq_pop  = m_tvalid && m_tready && !(oq_full && 1'b0);
  assign res     = res_t'(oq_head);
  assign m_tdata = {(OUT_TDATA_W-50)'(0), res.dropped, res.entry_count,
                    res.value, res.col, res.row};
  assign m_tlast = res.last_out;

endmodule

`default_nettype wire

// ===== rtl/core/stft_checker.sv =====
`default_nettype none
`include "sparse_triplet_fast_transpose_top_macros.svh"

module stft_checker #(
  parameter int MAX_ENTRIES = 64
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [stft_pkg::OUT_TDATA_W-1:0] m_tdata,
  input wire logic                             m_tlast
);

  // A stalled result stays put
  `STFT_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // entry_count (bits 48:42) never exceeds capacity
  `STFT_ASSERT_NOW(a_count_cap, clk, rst, m_tvalid, m_tdata[48:42] <= 7'(MAX_ENTRIES))

  // An empty matrix gives a single terminating result with zero row, column and value
  `STFT_ASSERT_NOW(a_empty_result, clk, rst, m_tvalid && (m_tdata[48:42] == 7'd0), m_tlast && (m_tdata[41:0] == 42'd0))

  // Nothing is offered in the cycle after reset
  `STFT_ASSERT_ALWAYS(a_reset_quiet, clk, $past(rst), !m_tvalid)

endmodule

bind sparse_triplet_fast_transpose_top stft_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_stft_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
